// File: hdl/tick_round_robin_task_switcher_macros.svh
// assertion macros shared by the task switcher rtl
`ifndef TICK_ROUND_ROBIN_TASK_SWITCHER_MACROS_SVH
`define TICK_ROUND_ROBIN_TASK_SWITCHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TRRTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("task switcher check failed");

// next-cycle implication, checked outside reset
`define TRRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("task switcher check failed");

`endif

// File: hdl/trrts_pkg.sv
// types and constants of the tick round-robin task switcher
`timescale 1ns / 1ps

package trrts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TASK_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION = 2'd1;

    localparam logic [15:0] SLICE_RESET   = 16'd10;
    localparam logic [15:0] SESSION_RESET = 16'd500;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [2:0]  task_index;
        logic [3:0]  task_total;
        logic [31:0] cur_pc;
        logic [31:0] cur_sp;
    } t_in_item;

    typedef struct packed {
        logic        redirect;
        logic [31:0] next_pc;
        logic [31:0] next_sp;
        logic        switching_on;
    } t_out_item;

    // context table write request
    typedef struct packed {
        logic              we;
        logic [TASK_W-1:0] idx;
        logic [31:0]       pc;
        logic [31:0]       sp;
    } t_ctx_wr;

    // one saved context
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] sp;
    } t_ctx;

    // configuration write transaction
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_wr;

endpackage

// File: hdl/trrts_ctx_table.sv
// per-task pc and sp table with write-to-read bypass
`timescale 1ns / 1ps

module trrts_ctx_table
    import trrts_pkg::*;
(
    input  logic              i_clk,
    input  t_ctx_wr           i_wr,
    input  logic [TASK_W-1:0] i_rd_idx,
    output t_ctx              o_rd
);

    t_ctx r_tbl [MAX_TASKS];

    // table write, no reset: entries are undefined until written
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_tbl[i_wr.idx] <= '{pc: i_wr.pc, sp: i_wr.sp};
        end
    end

    // read one slot, the context saved in this same transaction wins
    always_comb begin
        if (i_wr.we && (i_wr.idx == i_rd_idx)) begin
            o_rd = '{pc: i_wr.pc, sp: i_wr.sp};
        end else begin
            o_rd = r_tbl[i_rd_idx];
        end
    end

endmodule

// File: hdl/trrts_sched.sv
// scheduler state, config registers and per-item decision logic
`timescale 1ns / 1ps

module trrts_sched
    import trrts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [15:0]       r_slice_ticks,   n_slice_ticks;
    logic [15:0]       r_session_ticks, n_session_ticks;
    logic [TASK_W-1:0] r_cur_task,      n_cur_task;
    logic [CNT_W-1:0]  r_active_count,  n_active_count;
    logic              r_enabled,       n_enabled;
    logic              r_started,       n_started;
    logic [15:0]       r_session_left,  n_session_left;
    logic [31:0]       r_tick_now,      n_tick_now;
    logic [31:0]       r_slice_mark,    n_slice_mark;

    t_ctx_wr           wr_raw;
    t_ctx_wr           wr;
    logic [TASK_W-1:0] rd_idx;
    t_ctx              rd;
    logic              use_tbl;
    logic [TASK_W-1:0] nxt_task;
    logic [31:0]       npc;
    logic [31:0]       nsp;

    // next task in rotation over 1..count-1
    always_comb begin
        if (CNT_W'(r_cur_task) >= (r_active_count - CNT_W'(1))) begin
            nxt_task = TASK_W'(1);
        end else begin
            nxt_task = r_cur_task + TASK_W'(1);
        end
    end

    // configuration register writes
    always_comb begin
        n_slice_ticks   = r_slice_ticks;
        n_session_ticks = r_session_ticks;
        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_SLICE:   n_slice_ticks   = i_cfg.data;
                CFG_SESSION: n_session_ticks = i_cfg.data;
                default:     ;
            endcase
        end
    end

    // per-item decision
    always_comb begin
        n_cur_task     = r_cur_task;
        n_active_count = r_active_count;
        n_enabled      = r_enabled;
        n_started      = r_started;
        n_session_left = r_session_left;
        n_tick_now     = r_tick_now;
        n_slice_mark   = r_slice_mark;
        wr_raw         = '{we: 1'b0, idx: i_item.task_index[TASK_W-1:0],
                           pc: i_item.cur_pc, sp: i_item.cur_sp};
        rd_idx         = r_cur_task;
        use_tbl        = 1'b0;
        unique case (i_item.action)
            ACT_TICK: begin
                if ((r_active_count > CNT_W'(1)) && r_enabled) begin
                    if (!r_started) begin
                        // first tick of a session resumes the current task
                        use_tbl      = 1'b1;
                        n_slice_mark = r_tick_now;
                        n_started    = 1'b1;
                    end else begin
                        n_session_left = r_session_left - 16'd1;
                        // end of slice: save interrupted context, rotate
                        if ((r_slice_mark + {16'd0, r_slice_ticks}) == r_tick_now) begin
                            n_slice_mark = r_tick_now;
                            wr_raw.we    = 1'b1;
                            wr_raw.idx   = r_cur_task;
                            n_cur_task   = nxt_task;
                            rd_idx       = nxt_task;
                            use_tbl      = 1'b1;
                        end
                        // session over: back to task zero, switching off
                        if (n_session_left == 16'd0) begin
                            n_cur_task     = TASK_W'(1);
                            n_session_left = r_session_ticks;
                            n_active_count = CNT_W'(1);
                            rd_idx         = '0;
                            use_tbl        = 1'b1;
                            n_started      = 1'b0;
                            n_enabled      = 1'b0;
                        end
                    end
                end
                n_tick_now = r_tick_now + 32'd1;
            end
            ACT_START: begin
                if (int'(i_item.task_total) > MAX_TASKS) begin
                    n_active_count = CNT_W'(MAX_TASKS);
                end else begin
                    n_active_count = CNT_W'(i_item.task_total);
                end
                n_enabled = 1'b1;
            end
            ACT_WRITE: begin
                wr_raw.we = (int'(i_item.task_index) < MAX_TASKS);
            end
            ACT_NONE: ;
            default:  ;
        endcase
    end

    // table writes only on the transaction that moves forward
    always_comb begin
        wr    = wr_raw;
        wr.we = wr_raw.we && i_advance;
    end

    trrts_ctx_table u_ctx_table (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_rd_idx (rd_idx),
        .o_rd     (rd)
    );

    // result of this item
    always_comb begin
        npc = use_tbl ? rd.pc : i_item.cur_pc;
        nsp = use_tbl ? rd.sp : i_item.cur_sp;
        o_result.redirect     = (npc != i_item.cur_pc) || (nsp != i_item.cur_sp);
        o_result.next_pc      = npc;
        o_result.next_sp      = nsp;
        o_result.switching_on = n_enabled;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_ticks   <= SLICE_RESET;
            r_session_ticks <= SESSION_RESET;
            r_cur_task      <= TASK_W'(1);
            r_active_count  <= CNT_W'(1);
            r_enabled       <= 1'b0;
            r_started       <= 1'b0;
            r_session_left  <= SESSION_RESET;
            r_tick_now      <= 32'd1;
            r_slice_mark    <= 32'd1;
        end else begin
            r_slice_ticks   <= n_slice_ticks;
            r_session_ticks <= n_session_ticks;
            if (i_advance) begin
                r_cur_task     <= n_cur_task;
                r_active_count <= n_active_count;
                r_enabled      <= n_enabled;
                r_started      <= n_started;
                r_session_left <= n_session_left;
                r_tick_now     <= n_tick_now;
                r_slice_mark   <= n_slice_mark;
            end
        end
    end

endmodule

// File: hdl/tick_round_robin_task_switcher.sv
// Tick round-robin task switcher top level.
// Input channel i_in_valid / o_in_stall / i_in_data carries one transaction
// per item: a timer tick with the interrupted pc and sp, a start that sets
// the task count, or a write of one task context into the table.
// Output channel o_out_valid / i_out_stall / o_out_data returns exactly one
// result per item: the pc and sp to resume, a redirect flag and the
// switching-enabled status.
// Configuration channel i_cfg_valid / o_cfg_ready writes slice_ticks
// (index 0) or session_ticks (index 1); ready is always high.
// An accepted item waits in the input register; when it advances, the decision
// logic fills the output register, which drives o_out_valid and o_out_data.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single decision stage between the input and output registers.
// When the receiver stalls, the output register holds its result, the input
// register still accepts one more item, and o_in_stall rises only once both
// registers are full.
// Synchronous active-low reset empties both registers, loads slice_ticks 10
// and session_ticks 500, and clears the scheduler; the context table is not
// cleared and holds no valid data until written.
`timescale 1ns / 1ps

module tick_round_robin_task_switcher
    import trrts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

`include "tick_round_robin_task_switcher_macros.svh"

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      advance;
    logic      in_take;
    t_out_item result;
    t_cfg_wr   cfg;

    // pipeline control
    assign advance     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // configuration transaction
    assign o_cfg_ready = 1'b1;
    assign cfg = '{we: i_cfg_valid && o_cfg_ready, idx: i_cfg_index, data: i_cfg_data};

    trrts_sched u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_item    (r_in),
        .o_result  (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    // checks
    `TRRTS_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, o_in_stall, r_in_vld)
    `TRRTS_ASSERT_NOW(a_empty_out_no_stall, i_clk, i_rst_n, !r_out_vld, !o_in_stall)
    `TRRTS_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_vld)
    `TRRTS_ASSERT_NEXT(a_no_redirect_off_tick, i_clk, i_rst_n, advance && (r_in.action != ACT_TICK), !o_out_data.redirect)

endmodule

// File: dv/tick_round_robin_task_switcher_chk.sv
// scoreboard for the task switcher: predicts every result and compares it on the output channel
`timescale 1ns / 1ps

module tick_round_robin_task_switcher_chk
    import trrts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // scheduler image kept alongside the block
    logic [31:0]       ctx_pc [MAX_TASKS];
    logic [31:0]       ctx_sp [MAX_TASKS];
    logic [TASK_W-1:0] cur_task;
    logic [CNT_W-1:0]  task_count;
    logic              switching;
    logic              running;
    logic [15:0]       session_rem;
    logic [31:0]       tick_count;
    logic [31:0]       slice_start;
    logic [15:0]       slice_len;
    logic [15:0]       session_reload;

    t_out_item resume_queue [$];
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // resume context and switching status after one input transaction
    function automatic t_out_item resume_after(input t_in_item it);
        t_out_item   res;
        logic [31:0] npc;
        logic [31:0] nsp;
        npc = it.cur_pc;
        nsp = it.cur_sp;
        case (it.action)
            ACT_TICK: begin
                if (task_count > 1 && switching) begin
                    if (!running) begin
                        // first tick of a session resumes the current task
                        npc = ctx_pc[cur_task];
                        nsp = ctx_sp[cur_task];
                        slice_start = tick_count;
                        running = 1'b1;
                    end else begin
                        session_rem = session_rem - 16'd1;
                        // slice boundary: save interrupted context, rotate among 1..count-1
                        if (slice_start + 32'(slice_len) == tick_count) begin
                            slice_start = tick_count;
                            ctx_pc[cur_task] = it.cur_pc;
                            ctx_sp[cur_task] = it.cur_sp;
                            if (cur_task >= task_count - 1)
                                cur_task = TASK_W'(1);
                            else
                                cur_task = cur_task + TASK_W'(1);
                            npc = ctx_pc[cur_task];
                            nsp = ctx_sp[cur_task];
                        end
                        // session over: back to task zero, switching off
                        if (session_rem == 16'd0) begin
                            cur_task = TASK_W'(1);
                            session_rem = session_reload;
                            task_count = CNT_W'(1);
                            npc = ctx_pc[0];
                            nsp = ctx_sp[0];
                            running = 1'b0;
                            switching = 1'b0;
                        end
                    end
                end
                tick_count = tick_count + 32'd1;
            end
            ACT_START: begin
                task_count = (it.task_total > MAX_TASKS) ? CNT_W'(MAX_TASKS) : it.task_total;
                switching = 1'b1;
            end
            ACT_WRITE: begin
                ctx_pc[it.task_index] = it.cur_pc;
                ctx_sp[it.task_index] = it.cur_sp;
            end
            default: ;
        endcase
        res.redirect     = (npc != it.cur_pc) || (nsp != it.cur_sp);
        res.next_pc      = npc;
        res.next_sp      = nsp;
        res.switching_on = switching;
        return res;
    endfunction

    // watch all three channels at each clock edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cur_task       = TASK_W'(1);
            task_count     = CNT_W'(1);
            switching      = 1'b0;
            running        = 1'b0;
            session_rem    = SESSION_RESET;
            tick_count     = 32'd1;
            slice_start    = 32'd1;
            slice_len      = SLICE_RESET;
            session_reload = SESSION_RESET;
            resume_queue.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLICE:   slice_len = i_cfg_data;
                    CFG_SESSION: session_reload = i_cfg_data;
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (resume_queue.size() == 0) begin
                    flag_mismatch("unexpected result", i_out_data.next_pc, 32'd0);
                end else begin
                    want = resume_queue.pop_front();
                    if (i_out_data.redirect !== want.redirect)
                        flag_mismatch("redirect", 32'(i_out_data.redirect),
                                      32'(want.redirect));
                    if (i_out_data.next_pc !== want.next_pc)
                        flag_mismatch("next_pc", i_out_data.next_pc, want.next_pc);
                    if (i_out_data.next_sp !== want.next_sp)
                        flag_mismatch("next_sp", i_out_data.next_sp, want.next_sp);
                    if (i_out_data.switching_on !== want.switching_on)
                        flag_mismatch("switching_on", 32'(i_out_data.switching_on),
                                      32'(want.switching_on));
                end
            end
            // input transaction
            if (i_in_valid && !i_in_stall)
                resume_queue.push_back(resume_after(i_in_data));
        end
        o_pending <= resume_queue.size();
    end

endmodule

// File: dv/tick_round_robin_task_switcher_tb.sv
// testbench top for the task switcher: clock, reset, stimulus phases and verdict
`timescale 1ns / 1ps

module tick_round_robin_task_switcher_tb;
    import trrts_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   gaps_on     = 1'b1;
    logic stall_on    = 1'b1;
    int   stall_left  = 0;

    tick_round_robin_task_switcher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tick_round_robin_task_switcher_chk chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stalls in random bursts while stall_on is set
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic t_in_item make_item(input t_action act, input logic [2:0] idx,
                                           input logic [3:0] total, input logic [31:0] pc,
                                           input logic [31:0] sp);
        t_in_item it;
        it.action     = act;
        it.task_index = idx;
        it.task_total = total;
        it.cur_pc     = pc;
        it.cur_sp     = sp;
        return it;
    endfunction

    // words from a small pool often, so saved and interrupted contexts coincide
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // mostly ticks, with starts, context writes and the odd unused action
    function automatic t_in_item random_item();
        int     pick;
        t_in_item it;
        pick = $urandom_range(0, 99);
        it = make_item(ACT_TICK, 3'($urandom), 4'($urandom), random_word(), random_word());
        if (pick < 70) begin
            it.action = ACT_TICK;
        end else if (pick < 80) begin
            it.action = ACT_START;
            if ($urandom_range(0, 3) != 0)
                it.task_total = 4'($urandom_range(2, MAX_TASKS));
        end else if (pick < 95) begin
            it.action = ACT_WRITE;
        end else begin
            it.action = ACT_NONE;
        end
        return it;
    endfunction

    // one input transaction, with an optional sender gap ahead of it
    task automatic send_item(input t_in_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic run_items(input int count);
        for (int n = 0; n < count; n++)
            send_item(random_item());
        in_valid <= 1'b0;
    endtask

    // wait until every expected result has come, then let the pipeline empty
    task automatic settle();
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_transaction(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] slice_val, input logic [15:0] session_val);
        cfg_transaction(CFG_SLICE, slice_val);
        cfg_transaction(CFG_SESSION, session_val);
        cfg_transaction(CFG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] seed_pc [MAX_TASKS];
        logic [31:0] seed_sp [MAX_TASKS];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every context slot, all-zero and all-one words in slots 0 and 1
        for (int i = 0; i < MAX_TASKS; i++) begin
            seed_pc[i] = $urandom;
            seed_sp[i] = $urandom;
        end
        seed_pc[0] = 32'h0000_0000;
        seed_sp[0] = 32'hffff_ffff;
        seed_pc[1] = 32'hffff_ffff;
        seed_sp[1] = 32'h0000_0000;
        for (int i = 0; i < MAX_TASKS; i++)
            send_item(make_item(ACT_WRITE, 3'(i), 4'($urandom), seed_pc[i], seed_sp[i]));

        // unused action and a tick before any start pass straight through
        send_item(make_item(ACT_NONE, 3'd7, 4'd15, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_item(ACT_TICK, 3'd0, 4'd0, $urandom, $urandom));
        // task totals of 0 and 1 enable switching but ticks do nothing
        send_item(make_item(ACT_START, 3'd0, 4'd0, $urandom, $urandom));
        send_item(make_item(ACT_TICK, 3'd0, 4'd0, $urandom, $urandom));
        send_item(make_item(ACT_START, 3'd0, 4'd1, $urandom, $urandom));
        send_item(make_item(ACT_TICK, 3'd0, 4'd0, $urandom, $urandom));
        // oversized total saturates; first tick resumes task 1 with no redirect
        send_item(make_item(ACT_START, 3'd0, 4'd15, $urandom, $urandom));
        send_item(make_item(ACT_TICK, 3'd0, 4'd0, seed_pc[1], seed_sp[1]));
        // one full default slice, ending in the switch to task 2
        repeat (10)
            send_item(make_item(ACT_TICK, 3'($urandom), 4'($urandom), $urandom, $urandom));

        // reset register values
        run_items(200);
        settle();
        // largest slice and session
        program_regs(16'hffff, 16'hffff);
        run_items(200);
        settle();
        program_regs(16'd3, 16'd2);
        run_items(275);
        settle();
        // smallest nonzero slice and session
        program_regs(16'd1, 16'd1);
        run_items(275);
        settle();
        // zero slice never matches again
        program_regs(16'd0, 16'd4);
        run_items(250);
        settle();
        program_regs(16'($urandom_range(2, 6)), 16'($urandom_range(2, 30)));
        run_items(350);
        settle();
        // zero session reload wraps; no idling on either side
        gaps_on = 1'b0;
        stall_on <= 1'b0;
        program_regs(16'd1, 16'd0);
        run_items(275);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
